// ===== rtl/core/oph_pkg.sv =====
// Package with the shared constants and types of the ordinal pattern histogram.
package oph_pkg;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned TOL_BITS    = 32;
  localparam int unsigned RES_BITS    = SAMPLE_BITS + 1;
  localparam int unsigned DIFF_BITS   = RES_BITS + 1;
  localparam int unsigned CMP_BITS    = (DIFF_BITS > TOL_BITS) ? DIFF_BITS : TOL_BITS;
  localparam int unsigned NUM_BINS    = 24;
  localparam int unsigned BIN_BITS    = $clog2(NUM_BINS);
  localparam int unsigned WIN_HELD    = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(NUM_BINS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [1:0]            FILL_FULL = 2'(WIN_HELD);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [RES_BITS-1:0]    residual_t;
  typedef logic [BIN_BITS-1:0]           bin_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [TOL_BITS-1:0]           tol_t;

  typedef struct packed {
    logic count_en;
    bin_t code;
    logic last;
  } oph_cmd_t;

endpackage

// ===== rtl/core/oph_if.sv =====
// Handshake interfaces for the sample, result and configuration channels.
interface oph_in_if import oph_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t actual_value;
  sample_t predicted_value;
  logic    sample_missing;
  logic    last_of_series;

  modport source (output valid, actual_value, predicted_value, sample_missing,
                  last_of_series, input ready);
  modport sink (input valid, actual_value, predicted_value, sample_missing,
                last_of_series, output ready);
endinterface

interface oph_out_if import oph_pkg::*; ();
  logic   valid;
  logic   ready;
  bin_t   pattern_index;
  count_t pattern_count;
  logic   last_bin;

  modport source (output valid, pattern_index, pattern_count, last_bin, input ready);
  modport sink (input valid, pattern_index, pattern_count, last_bin, output ready);
endinterface

interface oph_cfg_if import oph_pkg::*; ();
  logic valid;
  logic ready;
  tol_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/oph_front.sv =====
// Front end: residual stage, residual window and ordinal code classification.
module oph_front import oph_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  oph_in_if.sink       in_i,
  oph_cfg_if.sink      cfg_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output oph_cmd_t     push_data_o
);

  function automatic logic rel(residual_t xa, residual_t xb, tol_t tol);
    logic signed [DIFF_BITS-1:0] d;
    logic [CMP_BITS-1:0]         du;
    logic [CMP_BITS-1:0]         tu;
    d  = DIFF_BITS'(xa) - DIFF_BITS'(xb);
    du = CMP_BITS'(unsigned'(d));
    tu = CMP_BITS'(tol);
    return d[DIFF_BITS-1] || (d == '0) || (du < tu);
  endfunction

  tol_t      tol_q;
  logic      s1_valid_q, s1_valid_d;
  residual_t s1_res_q;
  logic      s1_miss_q;
  logic      s1_last_q;
  residual_t win_q [WIN_HELD];
  logic      mark_q [WIN_HELD];
  logic [1:0] fill_q;
  logic      accept;
  logic      push;
  logic      c10, c20, c30, c21, c31, c32;
  logic [2:0] code_hi;
  logic [1:0] code_lo;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !s1_valid_q || push_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign push        = s1_valid_q && push_ready_i;
  assign s1_valid_d  = accept ? 1'b1 : (push ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_miss_q <= in_i.sample_missing;
      s1_last_q <= in_i.last_of_series;
      if (in_i.sample_missing) begin
        s1_res_q <= '0;
      end else begin
        s1_res_q <= RES_BITS'(in_i.actual_value) - RES_BITS'(in_i.predicted_value);
      end
    end
  end

  assign c10 = rel(win_q[1], win_q[0], tol_q);
  assign c20 = rel(win_q[2], win_q[0], tol_q);
  assign c30 = rel(s1_res_q, win_q[0], tol_q);
  assign c21 = rel(win_q[2], win_q[1], tol_q);
  assign c31 = rel(s1_res_q, win_q[1], tol_q);
  assign c32 = rel(s1_res_q, win_q[2], tol_q);

  assign code_hi = {1'b0, c32, c32} + {2'b00, c21} + {2'b00, c31};
  assign code_lo = {1'b0, c10} + {1'b0, c20} + {1'b0, c30};

  assign push_valid_o         = s1_valid_q;
  assign push_data_o.code     = {code_hi, code_lo};
  assign push_data_o.last     = s1_last_q;
  assign push_data_o.count_en = (fill_q == FILL_FULL) && !s1_miss_q &&
                                !mark_q[0] && !mark_q[1] && !mark_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int i = 0; i < WIN_HELD; i++) begin
        win_q[i]  <= '0;
        mark_q[i] <= 1'b0;
      end
    end else if (push) begin
      if (s1_last_q) begin
        fill_q <= '0;
        for (int i = 0; i < WIN_HELD; i++) begin
          win_q[i]  <= '0;
          mark_q[i] <= 1'b0;
        end
      end else begin
        win_q[0]  <= win_q[1];
        win_q[1]  <= win_q[2];
        win_q[2]  <= s1_res_q;
        mark_q[0] <= mark_q[1];
        mark_q[1] <= mark_q[2];
        mark_q[2] <= s1_miss_q;
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + 2'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/oph_queue.sv =====
// Short command queue between the classifying front end and the counter back end.
module oph_queue import oph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  oph_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output oph_cmd_t pop_data_o
);

  oph_cmd_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q;
  logic [QPTR_BITS-1:0] rd_ptr_q;
  logic [QPTR_BITS:0]   used_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (used_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (used_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        used_q <= used_q + 1'b1;
      end else if (pop && !push) begin
        used_q <= used_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/oph_back.sv =====
// Back end: saturating pattern counters and the end-of-series read-out.
module oph_back import oph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  oph_cmd_t pop_data_i,
  oph_out_if.source out_o
);

  typedef enum logic {
    ST_RUN,
    ST_DUMP
  } state_e;

  state_e state_q;
  count_t cnt_q [NUM_BINS];
  bin_t   bin_q;
  logic   out_valid_q;
  bin_t   out_index_q;
  count_t out_count_q;
  logic   out_last_q;
  logic   pop;
  logic   load;

  assign pop_ready_o = (state_q == ST_RUN);
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = (state_q == ST_DUMP) && (!out_valid_q || out_o.ready);

  assign out_o.valid         = out_valid_q;
  assign out_o.pattern_index = out_index_q;
  assign out_o.pattern_count = out_count_q;
  assign out_o.last_bin      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (out_valid_q && out_o.ready) begin
            out_valid_q <= 1'b0;
          end
          if (pop && pop_data_i.last) begin
            state_q <= ST_DUMP;
            bin_q   <= '0;
          end
        end
        ST_DUMP: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_index_q <= bin_q;
            out_count_q <= cnt_q[bin_q];
            out_last_q  <= (bin_q == LAST_BIN);
            bin_q       <= bin_q + 1'b1;
            if (bin_q == LAST_BIN) begin
              state_q <= ST_RUN;
            end
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (load) begin
      cnt_q[bin_q] <= '0;
    end else if (pop && pop_data_i.count_en && (cnt_q[pop_data_i.code] != COUNT_MAX)) begin
      cnt_q[pop_data_i.code] <= cnt_q[pop_data_i.code] + 1'b1;
    end
  end

endmodule

// ===== rtl/core/ordinal_pattern_histogram.sv =====
// Top level of the ordinal pattern histogram of prediction residuals.
// The block takes one sample word per cycle unless a full queue stalls it. A word
// passes through a residual register in the front end, is classified there and
// enters a four-entry command queue, from which the back end pops it to update
// its counter when it is not reading out.
// A word flagged last of series makes the back end read out the 24 counters,
// one result word per cycle through its output register while the output is
// not stalled, clearing each bin as it goes. During the read-out the front end
// keeps accepting words until the queue and residual register are full, after
// which input waits for the read-out to finish. The tolerance register may be
// written at any time the block holds no pending word; a write is always taken.
module ordinal_pattern_histogram import oph_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  oph_in_if.sink     in_i,
  oph_cfg_if.sink    cfg_i,
  oph_out_if.source  out_o
);

  logic     push_valid;
  logic     push_ready;
  oph_cmd_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  oph_cmd_t pop_data;

  oph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  oph_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  oph_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

  a_last_bin_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_bin |-> out_o.pattern_index == LAST_BIN)
    else $error("last bin flag on a word that is not the final bin");

  a_bin_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_bin |=>
      !out_o.valid || out_o.pattern_index == BIN_BITS'($past(out_o.pattern_index) + 1'b1))
    else $error("result bins out of order");

  a_no_pop_in_dump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready && pop_data.last |=> !pop_ready)
    else $error("queue popped while the counters are being read out");

  a_push_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |=> push_valid && $stable(push_data))
    else $error("stalled command changed before it entered the queue");

endmodule
